// File: rtl/core/xor_delta_run_bit_packer_assert.svh
// assertion helpers used by the rtl file xdrbp_emit.sv
`ifndef XOR_DELTA_RUN_BIT_PACKER_ASSERT_SVH
`define XOR_DELTA_RUN_BIT_PACKER_ASSERT_SVH

// checked only out of reset
`define XDRBP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define XDRBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/xdrbp_pkg.sv
package xdrbp_pkg;

    // one input item as held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_item;

    // packed bytes produced by one item, lowest byte first
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;
        logic        eos;
    } t_burst;

    localparam logic [1:0] RUN_MAX  = 2'd3;
    localparam logic       FLAG_RUN = 1'b1;
    localparam logic       FLAG_LIT = 1'b0;

endpackage

// File: rtl/core/xdrbp_if.sv
// input channel: raw bytes
interface xdrbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// output channel: packed bytes
interface xdrbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;

    modport source (output valid, output out_byte, output last_of_item,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input last_of_item,
                    input end_of_stream, output ready);
endinterface

// File: rtl/core/xdrbp_coder.sv
module xdrbp_coder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xdrbp_pkg::t_item i_item,
    input  logic             i_step,
    output xdrbp_pkg::t_burst o_burst
);

    // position of the highest set bit plus one
    function automatic logic [3:0] sig_length(input logic [7:0] v);
        logic [3:0] l;
        l = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                l = 4'(i + 1);
            end
        end
        return l;
    endfunction

    logic       r_started,   n_started;
    logic [7:0] r_prior,     n_prior;
    logic [7:0] r_past,      n_past;
    logic       r_run_open,  n_run_open;
    logic [1:0] r_run_extra, n_run_extra;
    logic [7:0] r_pack_bits, n_pack_bits;
    logic [2:0] r_pack_fill, n_pack_fill;

    logic [7:0]  delta;
    logic        same;
    logic        extend;
    logic        close;
    logic [3:0]  len;
    logic [12:0] lit;
    logic [16:0] code;
    logic [4:0]  code_n;
    logic [23:0] acc;
    logic [4:0]  total;
    logic [1:0]  full;
    logic [2:0]  rem;
    logic [1:0]  count;

    // code the item against the current stream state
    always_comb begin
        delta  = r_prior ^ i_item.in_byte;
        same   = (delta == r_past);
        extend = r_started && r_run_open && same && (r_run_extra != xdrbp_pkg::RUN_MAX);
        close  = r_started && r_run_open && !extend;
        len    = sig_length(delta);
        lit    = {delta, len, xdrbp_pkg::FLAG_LIT};

        code        = '0;
        code_n      = '0;
        n_started   = r_started;
        n_prior     = r_prior;
        n_past      = r_past;
        n_run_open  = r_run_open;
        n_run_extra = r_run_extra;

        if (!r_started) begin
            // raw first byte
            code      = {9'd0, i_item.in_byte};
            code_n    = 5'd8;
            n_started = 1'b1;
            n_prior   = i_item.in_byte;
        end else begin
            n_prior = i_item.in_byte;
            if (extend) begin
                n_run_extra = r_run_extra + 2'd1;
            end else begin
                if (close) begin
                    code        = {15'd0, r_run_extra};
                    code_n      = 5'd2;
                    n_run_open  = 1'b0;
                    n_run_extra = 2'd0;
                end
                if (same) begin
                    code        = code | (17'(xdrbp_pkg::FLAG_RUN) << code_n);
                    code_n      = code_n + 5'd1;
                    n_run_open  = 1'b1;
                    n_run_extra = 2'd0;
                end else begin
                    code   = code | (17'(lit) << code_n);
                    code_n = code_n + 5'd5 + {1'b0, len};
                    n_past = delta;
                end
            end
        end

        // end of stream closes an open run
        if (i_item.last_byte && n_run_open) begin
            code   = code | (17'(n_run_extra) << code_n);
            code_n = code_n + 5'd2;
        end

        // append to the held bits
        acc   = {16'd0, r_pack_bits} | (24'(code) << r_pack_fill);
        total = {2'd0, r_pack_fill} + code_n;
        full  = total[4:3];
        rem   = total[2:0];
        count = full + {1'b0, (i_item.last_byte && (rem != 3'd0))};

        case (full)
            2'd0:    n_pack_bits = acc[7:0];
            2'd1:    n_pack_bits = acc[15:8];
            default: n_pack_bits = acc[23:16];
        endcase
        n_pack_fill = rem;

        // stream over: back to the start
        if (i_item.last_byte) begin
            n_started   = 1'b0;
            n_prior     = '0;
            n_past      = '0;
            n_run_open  = 1'b0;
            n_run_extra = '0;
            n_pack_bits = '0;
            n_pack_fill = '0;
        end

        o_burst.bytes = acc;
        o_burst.count = count;
        o_burst.eos   = i_item.last_byte;
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_prior     <= '0;
            r_past      <= '0;
            r_run_open  <= 1'b0;
            r_run_extra <= '0;
            r_pack_bits <= '0;
            r_pack_fill <= '0;
        end else if (i_step) begin
            r_started   <= n_started;
            r_prior     <= n_prior;
            r_past      <= n_past;
            r_run_open  <= n_run_open;
            r_run_extra <= n_run_extra;
            r_pack_bits <= n_pack_bits;
            r_pack_fill <= n_pack_fill;
        end
    end

endmodule

// File: rtl/core/xdrbp_emit.sv
`include "xor_delta_run_bit_packer_assert.svh"

module xdrbp_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xdrbp_pkg::t_burst i_burst,
    input  logic              i_load_req,
    output logic              o_load_ok,
    xdrbp_out_if.source       o_out
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [1:0]  r_cnt;
    logic        r_eos;
    logic [23:0] r_bytes;

    logic fire;
    logic last_beat;
    logic load;

    // output side of the burst buffer
    always_comb begin
        last_beat = (r_idx == (r_cnt - 2'd1));
        fire      = o_out.valid && o_out.ready;
        o_load_ok = !r_valid || (fire && last_beat) || (i_burst.count == 2'd0);
        load      = i_load_req && o_load_ok && (i_burst.count != 2'd0);

        o_out.valid         = r_valid;
        o_out.last_of_item  = last_beat;
        o_out.end_of_stream = last_beat && r_eos;
        case (r_idx)
            2'd0:    o_out.out_byte = r_bytes[7:0];
            2'd1:    o_out.out_byte = r_bytes[15:8];
            default: o_out.out_byte = r_bytes[23:16];
        endcase
    end

    // burst control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_cnt   <= i_burst.count;
        end else if (fire) begin
            if (last_beat) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // burst payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_burst.bytes;
            r_eos   <= i_burst.eos;
        end
    end

    `XDRBP_ASSERT(a_idx_in_burst, i_clk, i_rst_n, r_valid |-> (r_idx < r_cnt), "index beyond burst")
    `XDRBP_ASSERT(a_drain_empties, i_clk, i_rst_n, (fire && last_beat && !load) |=> !r_valid, "burst not emptied")
    `XDRBP_ASSERT(a_eos_on_last, i_clk, i_rst_n, (o_out.valid && o_out.end_of_stream) |-> o_out.last_of_item, "end of stream off item end")
    `XDRBP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_valid, "burst valid after reset")

endmodule

// File: rtl/core/xor_delta_run_bit_packer.sv
// Byte stream compressor: the first byte goes out raw, later bytes as XOR
// deltas coded as run flags with 2-bit repeat counts or as length-prefixed
// literals, packed LSB first into bytes; last_byte ends the stream, closes an
// open run and flushes the partial byte. An accepted byte is held in the
// input register, coded combinationally and its packed bytes (zero to three)
// go to a burst buffer once it has room, which drives the output channel.
// The single-byte output channel sets the rate: an item yielding k bytes
// holds the output until all k (at most two, three at end of stream) are out,
// an item yielding none skips it; with one-byte items input is taken every
// cycle while the output keeps pace. No clearing pass is needed after reset.
module xor_delta_run_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xdrbp_in_if.sink    i_in,
    xdrbp_out_if.source o_out
);

    logic             r_in_valid;
    xdrbp_pkg::t_item r_item;
    xdrbp_pkg::t_burst w_burst;
    logic             w_load_ok;
    logic             accept;
    logic             step;

    // input register handshake
    always_comb begin
        i_in.ready = !r_in_valid || w_load_ok;
        accept     = i_in.valid && i_in.ready;
        step       = r_in_valid && w_load_ok;
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (w_load_ok) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.in_byte   <= i_in.in_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    xdrbp_coder u_coder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_step  (step),
        .o_burst (w_burst)
    );

    xdrbp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (w_burst),
        .i_load_req (r_in_valid),
        .o_load_ok  (w_load_ok),
        .o_out      (o_out)
    );

endmodule
